FILE: rtl/hkm_pkg.sv
package hkm_pkg;

    localparam int HK_SLOTS = 512;
    localparam int HK_AW = $clog2(HK_SLOTS);

    // request codes
    localparam logic [2:0] REQ_LOAD      = 3'd0;
    localparam logic [2:0] REQ_BIND_BTN  = 3'd1;
    localparam logic [2:0] REQ_BIND_AXIS = 3'd2;
    localparam logic [2:0] REQ_CLEAR     = 3'd3;
    localparam logic [2:0] REQ_DOWN      = 3'd4;
    localparam logic [2:0] REQ_PRESSED   = 3'd5;
    localparam logic [2:0] REQ_RELEASED  = 3'd6;

    // configuration register indexes
    localparam logic [1:0] CFG_LEFT_DZ  = 2'd0;
    localparam logic [1:0] CFG_RIGHT_DZ = 2'd1;
    localparam logic [1:0] CFG_TRIG_DZ  = 2'd2;

    // axis selector codes for the triggers
    localparam logic [3:0] AXIS_LT = 4'd8;
    localparam logic [3:0] AXIS_RT = 4'd9;

    localparam logic [14:0] STICK_FULL = 15'd32767;
    localparam logic [14:0] TRIG_FULL  = 15'd255;
    localparam logic [16:0] Q_ONE      = 17'd32768;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [8:0]         hotkey;
        logic [15:0]        button_mask;
        logic [3:0]         axis_sel;
        logic [15:0]        threshold;
        logic [15:0]        buttons;
        logic signed [15:0] left_x;
        logic signed [15:0] left_y;
        logic signed [15:0] right_x;
        logic signed [15:0] right_y;
        logic [7:0]         left_trigger;
        logic [7:0]         right_trigger;
    } hkm_req_t;

    typedef struct packed {
        logic active;
        logic bound;
    } hkm_rsp_t;

    typedef struct packed {
        logic        valid;
        logic        is_axis;
        logic [15:0] mask;
        logic [3:0]  axis;
        logic [16:0] thr;
    } hkm_entry_t;

    typedef struct packed {
        logic [15:0] buttons;
        logic [15:0] lx;
        logic [15:0] ly;
        logic [15:0] rx;
        logic [15:0] ry;
        logic [7:0]  lt;
        logic [7:0]  rt;
    } hkm_pad_t;

    typedef struct packed {
        logic [14:0] left;
        logic [14:0] right;
        logic [7:0]  trig;
    } hkm_dz_t;

    typedef struct packed {
        logic             rd_en;
        logic [HK_AW-1:0] rd_addr;
        logic [HK_AW-1:0] wr_addr;
        logic             bind_we;
        hkm_entry_t       bind_data;
        logic             down_we;
        logic             down_bit;
    } hkm_store_cmd_t;

endpackage

FILE: rtl/hkm_store.sv
module hkm_store
    import hkm_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  hkm_store_cmd_t cmd,
    output hkm_entry_t     entry,
    output logic           prev_down,
    output logic           clearing
);

    hkm_entry_t bind_mem [HK_SLOTS];
    logic       down_mem [HK_SLOTS];

    logic [HK_AW:0]   clr_cnt_reg;
    logic [HK_AW-1:0] clr_addr;
    hkm_entry_t       entry_reg;
    logic             down_rd_reg;

    assign clearing = (clr_cnt_reg != (HK_AW + 1)'(HK_SLOTS));
    assign clr_addr = clr_cnt_reg[HK_AW-1:0];

    // sweep after reset: every slot unbound, every last-down bit zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (clearing)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing)
        begin
            bind_mem[clr_addr] <= '0;
        end
        else if (cmd.bind_we)
        begin
            bind_mem[cmd.wr_addr] <= cmd.bind_data;
        end
        if (cmd.rd_en)
        begin
            entry_reg <= bind_mem[cmd.rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing)
        begin
            down_mem[clr_addr] <= 1'b0;
        end
        else if (cmd.down_we)
        begin
            down_mem[cmd.wr_addr] <= cmd.down_bit;
        end
        if (cmd.rd_en)
        begin
            down_rd_reg <= down_mem[cmd.rd_addr];
        end
    end

    assign entry     = entry_reg;
    assign prev_down = down_rd_reg;

endmodule

FILE: rtl/hkm_match.sv
module hkm_match
    import hkm_pkg::*;
(
    input  logic       clk,
    input  hkm_entry_t entry,
    input  hkm_pad_t   pad,
    input  hkm_dz_t    dz,
    output logic       down
);

    logic [15:0] raw;
    logic [15:0] mag;
    logic [14:0] dz_sel;
    logic [14:0] full;
    logic [14:0] span;
    logic        above_c;
    logic [15:0] diff_c;
    logic [31:0] prod_c;

    logic        valid_reg;
    logic        is_axis_reg;
    logic        btn_reg;
    logic        above_reg;
    logic        thr_zero_reg;
    logic [15:0] diff_reg;
    logic [31:0] prod_reg;

    // directional magnitude and dead zone of the bound axis
    always_comb
    begin
        raw    = '0;
        mag    = '0;
        dz_sel = '0;
        full   = STICK_FULL;
        if (!entry.axis[3])
        begin
            unique case (entry.axis[2:1])
                2'b00: raw = pad.lx;
                2'b01: raw = pad.ly;
                2'b10: raw = pad.rx;
                2'b11: raw = pad.ry;
                default: raw = '0;
            endcase
            dz_sel = entry.axis[2] ? dz.right : dz.left;
            // opposite side of the chosen direction reads as zero
            if (raw[15] == entry.axis[0])
            begin
                mag = raw[15] ? 16'(17'h10000 - 17'(raw)) : raw;
            end
        end
        else if (entry.axis == AXIS_LT)
        begin
            mag    = {8'b0, pad.lt};
            dz_sel = {7'b0, dz.trig};
            full   = TRIG_FULL;
        end
        else if (entry.axis == AXIS_RT)
        begin
            mag    = {8'b0, pad.rt};
            dz_sel = {7'b0, dz.trig};
            full   = TRIG_FULL;
        end
    end

    assign above_c = mag > {1'b0, dz_sel};
    assign diff_c  = mag - {1'b0, dz_sel};
    assign span    = (full > dz_sel) ? (full - dz_sel) : '0;
    assign prod_c  = {15'b0, entry.thr} * {17'b0, span};

    always_ff @(posedge clk)
    begin
        valid_reg    <= entry.valid;
        is_axis_reg  <= entry.is_axis;
        btn_reg      <= |(pad.buttons & entry.mask);
        above_reg    <= above_c;
        thr_zero_reg <= (entry.thr == '0);
        diff_reg     <= diff_c;
        prod_reg     <= prod_c;
    end

    // (mag - dz) * 32768 >= thr * (full - dz)
    assign down = valid_reg & (is_axis_reg
                  ? (above_reg ? ({1'b0, diff_reg, 15'b0} >= prod_reg) : thr_zero_reg)
                  : btn_reg);

endmodule

FILE: rtl/pad_hotkey_edge_mapper.sv
// Hotkey mapper for a gamepad snapshot. After reset the block sweeps its binding table and
// last-down bits, one slot a cycle; busy stays high until every slot is cleared. A
// transaction is taken when start is high and busy is low and runs through the accepting
// cycle, which issues the binding table read, then a registered threshold multiply, then the
// compare and last-down write-back; busy is high for the multiply and the compare. The result
// appears on result with done high for one cycle, the cycle in which busy drops, so a new
// start may be given while done is high. The receiver cannot stall: capture result whenever
// done is high. Dead-zone registers are to be written by the user through cfg_we, cfg_index
// and cfg_data only while no transaction is in flight; the block does not enforce this.
module pad_hotkey_edge_mapper
    import hkm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  hkm_req_t    req,
    output logic        done,
    output hkm_rsp_t    result,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [14:0] cfg_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]     state_reg;
    logic [1:0]     state_next;
    hkm_req_t       req_reg;
    hkm_pad_t       pad_reg;
    hkm_dz_t        dz_reg;
    logic           bound_reg;
    logic           bound_next;
    logic           done_reg;
    hkm_rsp_t       rsp_reg;
    hkm_rsp_t       rsp_next;

    logic           accept;
    logic           clearing;
    logic           slot_ok;
    logic           is_bind;
    logic           is_edge;
    hkm_store_cmd_t cmd;
    hkm_entry_t     entry;
    logic           prev_down;
    logic           cur_down;

    assign busy    = (state_reg != S_IDLE) | clearing;
    assign accept  = start & ~busy;
    assign slot_ok = 32'(req_reg.hotkey) < HK_SLOTS;
    assign is_bind = (req_reg.req_type == REQ_BIND_BTN) | (req_reg.req_type == REQ_BIND_AXIS);
    assign is_edge = (req_reg.req_type == REQ_PRESSED) | (req_reg.req_type == REQ_RELEASED);

    always_comb
    begin
        cmd           = '0;
        cmd.rd_en     = accept;
        cmd.rd_addr   = HK_AW'(req.hotkey);
        cmd.wr_addr   = HK_AW'(req_reg.hotkey);
        cmd.bind_we   = (state_reg == S_EVAL) & slot_ok
                        & (is_bind | (req_reg.req_type == REQ_CLEAR));
        cmd.down_we   = (state_reg == S_FIN) & slot_ok & is_edge;
        cmd.down_bit  = cur_down;
        if (is_bind)
        begin
            cmd.bind_data.valid = 1'b1;
            if (req_reg.req_type == REQ_BIND_AXIS)
            begin
                cmd.bind_data.is_axis = 1'b1;
                cmd.bind_data.axis    = req_reg.axis_sel;
                cmd.bind_data.thr     = ({1'b0, req_reg.threshold} > Q_ONE)
                                        ? Q_ONE : {1'b0, req_reg.threshold};
            end
            else
            begin
                cmd.bind_data.mask = req_reg.button_mask;
            end
        end
    end

    hkm_store u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .entry     (entry),
        .prev_down (prev_down),
        .clearing  (clearing)
    );

    hkm_match u_match (
        .clk   (clk),
        .entry (entry),
        .pad   (pad_reg),
        .dz    (dz_reg),
        .down  (cur_down)
    );

    always_comb
    begin
        if (!slot_ok)
        begin
            bound_next = 1'b0;
        end
        else if (is_bind)
        begin
            bound_next = 1'b1;
        end
        else if (req_reg.req_type == REQ_CLEAR)
        begin
            bound_next = 1'b0;
        end
        else
        begin
            bound_next = entry.valid;
        end
    end

    always_comb
    begin
        rsp_next.bound = bound_reg;
        rsp_next.active = 1'b0;
        if (slot_ok)
        begin
            if (req_reg.req_type == REQ_DOWN)
            begin
                rsp_next.active = cur_down;
            end
            else if (req_reg.req_type == REQ_PRESSED)
            begin
                rsp_next.active = cur_down & ~prev_down;
            end
            else if (req_reg.req_type == REQ_RELEASED)
            begin
                rsp_next.active = ~cur_down & prev_down;
            end
        end
    end

    always_comb
    begin
        unique case (state_reg)
            S_IDLE:  state_next = accept ? S_EVAL : S_IDLE;
            S_EVAL:  state_next = S_FIN;
            S_FIN:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            dz_reg    <= '0;
            pad_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_FIN);
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_LEFT_DZ:  dz_reg.left  <= cfg_data;
                    CFG_RIGHT_DZ: dz_reg.right <= cfg_data;
                    CFG_TRIG_DZ:  dz_reg.trig  <= cfg_data[7:0];
                    default:      dz_reg       <= dz_reg;
                endcase
            end
            if (accept && (req.req_type == REQ_LOAD))
            begin
                pad_reg.buttons <= req.buttons;
                pad_reg.lx      <= req.left_x;
                pad_reg.ly      <= req.left_y;
                pad_reg.rx      <= req.right_x;
                pad_reg.ry      <= req.right_y;
                pad_reg.lt      <= req.left_trigger;
                pad_reg.rt      <= req.right_trigger;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        if (state_reg == S_EVAL)
        begin
            bound_reg <= bound_next;
        end
        if (state_reg == S_FIN)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done   = done_reg;
    assign result = rsp_reg;

    // a result only ever follows the compare cycle
    a_done_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_FIN))
        else $error("result strobe without a finished transaction");

    // nothing is taken while the table sweep runs
    a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !accept)
        else $error("transaction accepted during table sweep");

    a_clear_unbinds: assert property (@(posedge clk) disable iff (!rst_n)
        done && (req_reg.req_type == REQ_CLEAR) |-> !result.bound)
        else $error("slot still bound after clear");

    a_bind_binds: assert property (@(posedge clk) disable iff (!rst_n)
        done && slot_ok && is_bind |-> result.bound)
        else $error("slot not bound after bind");

    a_quiet_non_query: assert property (@(posedge clk) disable iff (!rst_n)
        done && (req_reg.req_type != REQ_DOWN) && !is_edge |-> !result.active)
        else $error("active set for a request that is not a query");

endmodule
